>>> rtl/cfpq_pkg.sv
// Shared types and constants for the CAN frame priority queue.
`default_nettype none
package cfpq_pkg;
   localparam int DEPTH    = 16;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int ID_W     = 29;
   localparam int STD_ID_W = 11;
   localparam int LEN_W    = 4;
   localparam int PAY_W    = 64;
   localparam int BYTES    = PAY_W / 8;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef struct packed {
      logic [PAY_W-1:0] payload;
      logic [LEN_W-1:0] length;
      logic [ID_W-1:0]  identifier;
      logic             extended;
   } frame_type;

   typedef struct packed {
      logic      kind;
      frame_type frame;
   } item_type;

   typedef struct packed {
      frame_type        front;
      logic             front_valid;
      logic [CNT_W-1:0] count;
   } result_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      frame_type        wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_CMP,
      ST_PLACE,
      ST_FRONT,
      ST_RDWAIT
   } state_type;
endpackage
`default_nettype wire

>>> rtl/cfpq_mem.sv
// Frame store: one write port, one registered read port.
`default_nettype none
module cfpq_mem (
   input  wire                        clock,
   input  wire cfpq_pkg::mem_req_type mem_req,
   output cfpq_pkg::frame_type        rd_data
);
   import cfpq_pkg::*;

   frame_type mem [DEPTH];
   frame_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> rtl/cfpq_ctrl.sv
// Sequencer: sorted insert walk, remove, and front readout over the frame store.
`default_nettype none
module cfpq_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        item_valid,
   input  wire cfpq_pkg::item_type    item,
   output logic                       item_ready,
   output cfpq_pkg::mem_req_type      mem_req,
   input  wire cfpq_pkg::frame_type   rd_data,
   output logic                       res_valid,
   output cfpq_pkg::result_type       res,
   output logic [1:0]                 res_status,
   input  wire                        res_ack
);
   import cfpq_pkg::*;

   state_type        state_ff, state_in;
   item_type         item_ff, item_in;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] walk_ff, walk_in;
   logic [1:0]       status_ff, status_in;
   frame_type        new_frame;
   logic             new_behind;

   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] ofs);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, ofs};
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // standard ids keep 11 bits; bytes past the length read as zero
   always_comb begin
      new_frame = item_ff.frame;
      if (!new_frame.extended) begin
         new_frame.identifier = {{(ID_W - STD_ID_W){1'b0}},
                                 item_ff.frame.identifier[STD_ID_W-1:0]};
      end
      for (int b = 0; b < BYTES; b++) begin
         if (item_ff.frame.length <= LEN_W'(b)) begin
            new_frame.payload[b*8 +: 8] = 8'h00;
         end
      end
   end

   always_comb begin
      if (new_frame.extended != rd_data.extended) begin
         new_behind = !new_frame.extended;
      end else begin
         new_behind = new_frame.identifier >= rd_data.identifier;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
      item_ff   <= item_in;
      walk_ff   <= walk_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      front_in   = front_ff;
      count_in   = count_ff;
      walk_in    = walk_ff;
      status_in  = status_ff;
      item_ready = 1'b0;
      mem_req    = '0;
      res_valid  = 1'b0;
      res.count       = count_ff;
      res.front_valid = count_ff != '0;
      res.front       = (count_ff != '0) ? rd_data : '0;

      case (state_ff)
         ST_IDLE: begin
            item_ready = !reset;
            if (item_valid && !reset) begin
               item_in  = item;
               state_in = ST_START;
            end
         end
         ST_START: begin
            status_in = STAT_DONE;
            state_in  = ST_FRONT;
            if (item_ff.kind == KIND_INSERT) begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  status_in = STAT_FULL;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  walk_in  = count_ff;
                  if (count_ff == '0) begin
                     state_in = ST_PLACE;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = slot_of(front_ff, count_ff - CNT_W'(1));
                     state_in        = ST_CMP;
                  end
               end
            end else begin
               if (count_ff == '0) begin
                  status_in = STAT_EMPTY;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  front_in = (front_ff == IDX_W'(DEPTH - 1)) ? '0
                                                              : front_ff + IDX_W'(1);
               end
            end
         end
         ST_CMP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = slot_of(front_ff, walk_ff);
            if (new_behind) begin
               mem_req.wr_data = new_frame;
               state_in        = ST_FRONT;
            end else begin
               mem_req.wr_data = rd_data;
               walk_in         = walk_ff - CNT_W'(1);
               if (walk_ff == CNT_W'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = slot_of(front_ff, walk_ff - CNT_W'(2));
               end
            end
         end
         ST_PLACE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = front_ff;
            mem_req.wr_data = new_frame;
            state_in        = ST_FRONT;
         end
         ST_FRONT: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = front_ff;
            state_in        = ST_RDWAIT;
         end
         ST_RDWAIT: begin
            res_valid = 1'b1;
            if (res_ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res_status = status_ff;
endmodule
`default_nettype wire

>>> rtl/can_frame_priority_queue.sv
// CAN frame priority queue: top level with stream ports and result register.
// Remove, or insert into a full queue: START, FRONT, RDWAIT, then the result register.
// Insert: START; a CMP walk reads and moves one stored frame per cycle for each of the n
// frames ranked behind the new one (at most DEPTH - 1), then writes it; then FRONT, RDWAIT.
// One item in flight; the next is taken the cycle after its result is registered.
// Reset (synchronous) empties the queue; the frame store itself is not cleared.
`default_nettype none
module can_frame_priority_queue (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [103:0] req_tdata,  // extended, identifier[29], length[4], payload[64], zero pad
   input  wire          req_tuser,  // kind
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [103:0] rsp_tdata,  // count[5], front_valid, front_extended,
                                    // front_identifier[29], front_length[4], front_payload[64]
   output logic [1:0]   rsp_tuser   // status
);
   import cfpq_pkg::*;

   item_type    item;
   mem_req_type mem_req;
   frame_type   rd_data;
   result_type  res;
   logic [1:0]  res_status;
   logic        res_valid;
   logic        res_ack;
   logic        out_valid_ff;
   result_type  out_data_ff;
   logic [1:0]  out_status_ff;

   assign item.kind  = req_tuser;
   assign item.frame = req_tdata[$bits(frame_type)-1:0];

   cfpq_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   cfpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item       (item),
      .item_ready (req_tready),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .res_valid  (res_valid),
      .res        (res),
      .res_status (res_status),
      .res_ack    (res_ack)
   );

   assign res_ack = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_valid && res_ack) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (res_valid && res_ack) begin
         out_data_ff   <= res;
         out_status_ff <= res_status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_status_ff;
endmodule
`default_nettype wire
